FILE: rtl/core/vector_float_floor_top_macros.svh
// Assertion macros shared by the vector floor RTL.
`ifndef VECTOR_FLOAT_FLOOR_TOP_MACROS_SVH
`define VECTOR_FLOAT_FLOOR_TOP_MACROS_SVH
// Checks that an implication holds, with reset disabling it.
`define VFF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Checks that an implication holds in the next cycle.
`define VFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/vff_pkg.sv
// ----------------------------------------------------------------------------
// Vector floor package
// Lane format constants and the operation codes.
// ----------------------------------------------------------------------------
package vff_pkg;
    localparam int unsigned HalfW = 64;
    localparam int unsigned F32Mant = 23;
    localparam int unsigned F32Exp = 8;
    localparam int unsigned F64Mant = 52;
    localparam int unsigned F64Exp = 11;
    localparam int unsigned NumHalves = 2;

    typedef enum logic {
        OP_F32 = 1'b0,
        OP_F64 = 1'b1
    } t_op;
endpackage

FILE: rtl/core/vff_lane.sv
// ----------------------------------------------------------------------------
// Vector floor lane
// Combinational floor of one IEEE-754 value with the given field widths.
// ----------------------------------------------------------------------------
module vff_lane #(
    parameter int unsigned MANT = 23,
    parameter int unsigned EXPW = 8
) (
    input  logic [MANT+EXPW:0] i_bits,
    output logic [MANT+EXPW:0] o_bits
);
    localparam int unsigned W = MANT + EXPW + 1;
    localparam logic [EXPW-1:0] EMax = '1;
    localparam logic [EXPW-1:0] Bias = EMax >> 1;
    localparam logic [EXPW:0] IntExp = (EXPW + 1)'(Bias) + (EXPW + 1)'(MANT);

    logic [EXPW-1:0] exp_f;
    logic [MANT-1:0] mant_f;
    logic            neg;
    logic [EXPW:0]   frac;
    logic [W-1:0]    fmask;
    logic [W-1:0]    unit;
    logic [W-1:0]    bumped;

    assign exp_f  = i_bits[W-2 -: EXPW];
    assign mant_f = i_bits[MANT-1:0];
    assign neg    = i_bits[W-1];
    assign frac   = IntExp - {1'b0, exp_f};

    always_comb begin
        fmask = '0;
        unit  = '0;
        for (int k = 0; k < MANT; k++) begin
            if (frac > (EXPW + 1)'(k)) begin
                fmask[k] = 1'b1;
            end
            if (frac == (EXPW + 1)'(k)) begin
                unit[k] = 1'b1;
            end
        end
        if (frac == (EXPW + 1)'(MANT)) begin
            unit[MANT] = 1'b1;
        end
        bumped = i_bits + (neg ? unit : '0);
    end

    always_comb begin
        if (exp_f == EMax) begin
            o_bits = i_bits;
            if (mant_f != '0) begin
                o_bits[MANT-1] = 1'b1;
            end
        end else if ({1'b0, exp_f} >= IntExp) begin
            o_bits = i_bits;
        end else if (exp_f < Bias) begin
            if (exp_f == '0 && mant_f == '0) begin
                o_bits = i_bits;
            end else if (neg) begin
                o_bits = {1'b1, Bias, {MANT{1'b0}}};
            end else begin
                o_bits = '0;
            end
        end else if ((i_bits & fmask) == '0) begin
            o_bits = i_bits;
        end else begin
            o_bits = bumped & ~fmask;
        end
    end
endmodule

FILE: rtl/core/vff_half.sv
// ----------------------------------------------------------------------------
// Vector floor half
// Two fp32 lanes and one fp64 lane side by side; the format picks one.
// ----------------------------------------------------------------------------
module vff_half (
    input  logic                   i_dbl,
    input  logic [vff_pkg::HalfW-1:0] i_half,
    output logic [vff_pkg::HalfW-1:0] o_half
);
    import vff_pkg::*;

    logic [31:0] s0, s1;
    logic [63:0] d0;

    vff_lane #(.MANT(F32Mant), .EXPW(F32Exp)) u_s0 (.i_bits(i_half[31:0]), .o_bits(s0));
    vff_lane #(.MANT(F32Mant), .EXPW(F32Exp)) u_s1 (.i_bits(i_half[63:32]), .o_bits(s1));
    vff_lane #(.MANT(F64Mant), .EXPW(F64Exp)) u_d0 (.i_bits(i_half), .o_bits(d0));

    // Merge the lane results according to the format.
    assign o_half = i_dbl ? d0 : {s1, s0};
endmodule

FILE: rtl/core/vector_float_floor_top.sv
// ----------------------------------------------------------------------------
// Vector floor top
// Rounds each fp32 or fp64 lane of a 128-bit vector toward minus infinity.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid/o_ready) carries the format in i_operation
// (0: four fp32 lanes, 1: two fp64 lanes) and the vector in i_vector_low and
// i_vector_high. The output channel (o_valid/i_ready) returns the floored
// vector in o_result_low and o_result_high, same format and lane order.
// Each result is registered; a stall can hold it in the skid register first.
// Throughput is one vector per cycle while the receiver is ready; all lanes
// work in parallel and the single output register sets the rate.
// A skid register takes one item when the receiver stalls, so the input
// stays ready until both registers are full.
// Reset empties both registers; no result is shown afterward until a new
// transfer.
// ----------------------------------------------------------------------------
module vector_float_floor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [63:0] i_vector_low,
    input  logic [63:0] i_vector_high,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_low,
    output logic [63:0] o_result_high
);
    import vff_pkg::*;
    `include "vector_float_floor_top_macros.svh"

    logic [HalfW-1:0] f_low, f_high;
    logic             dbl;
    logic             r_valid, r_skid_valid;
    logic [HalfW-1:0] r_low, r_high, r_skid_low, r_skid_high;
    logic             in_xfer, out_xfer;

    assign dbl = (t_op'(i_operation) == OP_F64);

    vff_half u_low  (.i_dbl(dbl), .i_half(i_vector_low),  .o_half(f_low));
    vff_half u_high (.i_dbl(dbl), .i_half(i_vector_high), .o_half(f_high));

    assign o_ready  = !r_skid_valid;
    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = r_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_valid || out_xfer) begin
                r_valid      <= r_skid_valid || in_xfer;
                r_skid_valid <= 1'b0;
            end else if (in_xfer) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || out_xfer) begin
            r_low  <= r_skid_valid ? r_skid_low  : f_low;
            r_high <= r_skid_valid ? r_skid_high : f_high;
        end
        if (in_xfer) begin
            r_skid_low  <= f_low;
            r_skid_high <= f_high;
        end
    end

    assign o_valid       = r_valid;
    assign o_result_low  = r_low;
    assign o_result_high = r_high;

    `VFF_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_valid, "skid without output")
    `VFF_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_valid && !i_ready, r_valid && $stable(r_low), "stalled result changed")
    `VFF_ASSERT_NEXT(a_xfer_shows, i_clk, i_rst_n, in_xfer, r_valid, "transfer not shown")
endmodule
